@@ hw/rtl/chunked_transfer_job_engine_core_defines.svh @@
// ----------------------------------------------------------------------------
// Chunked transfer job engine assertion macros
// Concurrent checks clocked on a rising edge, switched off with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_TRANSFER_JOB_ENGINE_CORE_DEFINES_SVH
`define CHUNKED_TRANSFER_JOB_ENGINE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// check that a property holds at every rising edge out of reset
`define CTJ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ctj assertion failed");
// check that a condition never occurs out of reset
`define CTJ_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ctj forbidden condition seen");
`else
`define CTJ_ASSERT(label, clk, rst_n, prop)
`define CTJ_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/ctj_pkg.sv @@
// ----------------------------------------------------------------------------
// Chunked transfer job engine package
// Operation, result and phase codes and the control/status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ctj_pkg;

    // input operation codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_OFFER = 3'd1;
    localparam logic [2:0] OP_REQ   = 3'd2;
    localparam logic [2:0] OP_DATA  = 3'd3;
    localparam logic [2:0] OP_SEND  = 3'd4;
    localparam logic [2:0] OP_INIT  = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_REQUEST  = 3'd0;
    localparam logic [2:0] KIND_OFFER    = 3'd1;
    localparam logic [2:0] KIND_READ     = 3'd2;
    localparam logic [2:0] KIND_WRITE    = 3'd3;
    localparam logic [2:0] KIND_COMPLETE = 3'd4;

    // slot phases
    localparam logic [1:0] PH_FREE    = 2'd0;
    localparam logic [1:0] PH_OFFERED = 2'd1;
    localparam logic [1:0] PH_XFER    = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // register indexes
    localparam logic REG_TARGET_PORT   = 1'b0;
    localparam logic REG_STALL_TIMEOUT = 1'b1;

    localparam int MAX_RESULTS = 8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [31:0] ident;
        logic [47:0] offset;
        logic [31:0] length;
        logic [31:0] dest;
        logic [15:0] port;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic tick_upd;
        logic commit1;
        logic commit2;
        logic commit3;
        logic flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic stall_hit;
        logic push_ok;
        logic pend_v;
        logic out_free;
    } t_sts;

endpackage

@@ hw/rtl/ctj_ctrl.sv @@
// ----------------------------------------------------------------------------
// Chunked transfer job engine controller
// Sequences the slot scan, commit steps and result flush for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ctj_ctrl #(
    parameter int JOB_SLOTS = 8,
    parameter int IW        = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic [2:0]      i_op,
    output logic            o_s_tready,
    input  ctj_pkg::t_sts   i_sts,
    output ctj_pkg::t_cmd   o_cmd,
    output logic [IW-1:0]   o_idx
);
    import ctj_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_COMMIT1, S_COMMIT2, S_COMMIT3, S_FLUSH
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [IW-1:0] r_idx, n_idx;
    logic [3:0]    r_n, n_n;
    logic          w_last;
    logic          w_accept;

    assign w_last     = (r_idx == IW'(JOB_SLOTS - 1));
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = o_s_tready && i_s_tvalid;
    assign o_idx      = r_idx;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_idx   = r_idx;
        n_n     = r_n;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.clear = (i_op == OP_INIT);
                    n_op  = i_op;
                    n_idx = '0;
                    n_n   = '0;
                    if (i_op inside {OP_TICK, OP_OFFER, OP_REQ, OP_DATA, OP_SEND}) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_op == OP_TICK) begin
                    if (i_sts.stall_hit) begin
                        if (i_sts.push_ok) begin
                            o_cmd.tick_upd = 1'b1;
                            n_n = r_n + 4'd1;
                            if (w_last || r_n == 4'(MAX_RESULTS - 1)) begin
                                n_state = S_FLUSH;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                    end else if (w_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                    if (w_last) begin
                        n_state = S_COMMIT1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_COMMIT1: begin
                if (i_sts.push_ok) begin
                    o_cmd.commit1 = 1'b1;
                    n_state = (r_op == OP_DATA) ? S_COMMIT2 : S_FLUSH;
                end
            end
            S_COMMIT2: begin
                o_cmd.commit2 = 1'b1;
                n_state = S_COMMIT3;
            end
            S_COMMIT3: begin
                if (i_sts.push_ok) begin
                    o_cmd.commit3 = 1'b1;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_TICK;
            r_idx   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_idx   <= n_idx;
            r_n     <= n_n;
        end
    end

endmodule

@@ hw/rtl/ctj_dp.sv @@
// ----------------------------------------------------------------------------
// Chunked transfer job engine datapath
// Job table, slot finders, window arithmetic and the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ctj_dp #(
    parameter int          JOB_SLOTS   = 8,
    parameter int          IW          = 3,
    parameter logic [31:0] CHUNK_BYTES = 32'd1048576
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctj_pkg::t_cmd     i_cmd,
    input  logic [IW-1:0]     i_idx,
    output ctj_pkg::t_sts     o_sts,
    input  logic [2:0]        i_op,
    input  logic [223:0]      i_in_data,
    input  logic [15:0]       i_port,
    input  logic [7:0]        i_timeout,
    output logic              o_valid,
    input  logic              i_ready,
    output ctj_pkg::t_result  o_res,
    output logic              o_last
);
    import ctj_pkg::*;

    localparam logic [47:0] CHUNK48 = {16'd0, CHUNK_BYTES};
    localparam logic [47:0] MAX48   = {48{1'b1}};

    // latched item
    logic [2:0]  r_op;
    logic [31:0] r_now, r_id, r_cnt, r_addr;
    logic [47:0] r_fsize, r_off;

    // job table
    logic [1:0]  r_phase [JOB_SLOTS];
    logic [31:0] r_own   [JOB_SLOTS];
    logic [31:0] r_peer  [JOB_SLOTS];
    logic [31:0] r_ip    [JOB_SLOTS];
    logic [47:0] r_size  [JOB_SLOTS];
    logic [47:0] r_done  [JOB_SLOTS];
    logic [47:0] r_wend  [JOB_SLOTS];
    logic [31:0] r_act   [JOB_SLOTS];

    // finders
    logic          r_ofh, r_frh, r_xh, r_take;
    logic [IW-1:0] r_ofi, r_fri, r_xi;

    // result queue
    t_result r_pend, r_out;
    logic    r_pend_v, r_out_v, r_out_last;

    logic [IW-1:0] w_rd;
    logic [1:0]    w_phase;
    logic [47:0]   w_size, w_done, w_wend, w_rem, w_wlen, w_olen;
    logic [31:0]   w_own, w_peer, w_ip, w_act, w_age;
    logic [48:0]   w_sum;
    logic [47:0]   w_nd;
    logic          w_stall, w_out_free, w_push;
    t_result       w_new;

    // select the slot being read
    always_comb begin
        if (i_cmd.scan || i_cmd.tick_upd || r_op == OP_TICK) begin
            w_rd = i_idx;
        end else if (r_op == OP_REQ) begin
            w_rd = r_ofi;
        end else begin
            w_rd = r_xi;
        end
    end

    assign w_phase = r_phase[w_rd];
    assign w_own   = r_own[w_rd];
    assign w_peer  = r_peer[w_rd];
    assign w_ip    = r_ip[w_rd];
    assign w_size  = r_size[w_rd];
    assign w_done  = r_done[w_rd];
    assign w_wend  = r_wend[w_rd];
    assign w_act   = r_act[w_rd];

    // window length and stall test
    assign w_rem   = (w_done < w_size) ? (w_size - w_done) : 48'd0;
    assign w_wlen  = (w_rem < CHUNK48) ? w_rem : CHUNK48;
    assign w_olen  = (r_fsize < CHUNK48) ? r_fsize : CHUNK48;
    assign w_age   = r_now - w_act;
    assign w_stall = (w_phase == PH_XFER) && (w_done < w_wend) && (w_age > {24'd0, i_timeout});
    assign w_sum   = {1'b0, w_done} + {17'd0, r_cnt};
    assign w_nd    = w_sum[48] ? MAX48 : w_sum[47:0];

    assign w_out_free = !r_out_v || i_ready;
    assign o_sts.stall_hit = w_stall;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.pend_v    = r_pend_v;
    assign o_sts.push_ok   = !r_pend_v || w_out_free;

    // build the result of this step
    always_comb begin
        w_push = 1'b0;
        w_new  = '0;
        if (i_cmd.tick_upd) begin
            w_push = 1'b1;
            w_new  = '{KIND_REQUEST, 3'(i_idx), w_peer, w_done, w_wlen[31:0], w_ip, i_port};
        end else if (i_cmd.commit1) begin
            case (r_op)
                OP_OFFER: begin
                    w_push = !r_ofh && r_frh;
                    w_new  = '{KIND_REQUEST, 3'(r_fri), r_id, 48'd0, w_olen[31:0], r_addr,
                               i_port};
                end
                OP_REQ: begin
                    w_push = r_ofh;
                    w_new  = '{KIND_READ, 3'(r_ofi), w_own, r_off,
                               (r_cnt < CHUNK_BYTES) ? r_cnt : CHUNK_BYTES, r_addr, i_port};
                end
                OP_SEND: begin
                    w_push = r_frh;
                    w_new  = '{KIND_OFFER, 3'(r_fri), r_id, r_fsize,
                               (r_fsize[47:32] != 16'd0) ? 32'hFFFF_FFFF : r_fsize[31:0],
                               r_addr, i_port};
                end
                OP_DATA: begin
                    w_push = 1'b1;
                    w_new  = '{KIND_WRITE, r_xh ? 3'(r_xi) : 3'd0, 32'd0, r_off, r_cnt,
                               32'd0, 16'd0};
                end
                default: w_push = 1'b0;
            endcase
        end else if (i_cmd.commit3 && r_take) begin
            if (w_done < w_size) begin
                w_push = (w_done >= w_wend);
                w_new  = '{KIND_REQUEST, 3'(r_xi), w_peer, w_done, w_wlen[31:0], r_addr,
                           i_port};
            end else begin
                w_push = 1'b1;
                w_new  = '{KIND_COMPLETE, 3'(r_xi), w_peer, w_done, 32'd0, 32'd0, 16'd0};
            end
        end
    end

    // latch the item and run the finders
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_now   <= i_in_data[31:0];
            r_id    <= i_in_data[63:32];
            r_fsize <= i_in_data[111:64];
            r_off   <= i_in_data[159:112];
            r_cnt   <= i_in_data[191:160];
            r_addr  <= i_in_data[223:192];
            r_ofh   <= 1'b0;
            r_frh   <= 1'b0;
            r_xh    <= 1'b0;
            r_take  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (!r_ofh && w_phase == PH_OFFERED && w_own == r_id) begin
                r_ofh <= 1'b1;
                r_ofi <= i_idx;
            end
            if (!r_frh && w_phase == PH_FREE) begin
                r_frh <= 1'b1;
                r_fri <= i_idx;
            end
            if (!r_xh && w_phase == PH_XFER) begin
                r_xh <= 1'b1;
                r_xi <= i_idx;
            end
        end else if (i_cmd.commit2) begin
            r_take <= r_xh && (r_off == w_done);
        end
    end

    // update slot fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_upd) begin
            r_wend[i_idx] <= w_done + w_wlen;
            r_act[i_idx]  <= r_now;
        end else if (i_cmd.commit1 && r_op == OP_OFFER && !r_ofh && r_frh) begin
            r_size[r_fri] <= r_fsize;
            r_done[r_fri] <= 48'd0;
            r_peer[r_fri] <= r_id;
            r_ip[r_fri]   <= r_addr;
            r_wend[r_fri] <= w_olen;
            r_act[r_fri]  <= 32'd0;
        end else if (i_cmd.commit1 && r_op == OP_SEND && r_frh) begin
            r_own[r_fri]  <= r_id;
            r_size[r_fri] <= r_fsize;
        end else if (i_cmd.commit2 && r_xh && r_off == w_done) begin
            r_done[r_xi] <= w_nd;
            r_act[r_xi]  <= r_now;
        end else if (i_cmd.commit3 && r_take && w_done < w_size && w_done >= w_wend) begin
            r_wend[r_xi] <= w_done + w_wlen;
        end
    end

    // hold slot phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < JOB_SLOTS; k++) begin
                r_phase[k] <= PH_FREE;
            end
        end else if (i_cmd.commit1 && r_op == OP_OFFER && !r_ofh && r_frh) begin
            r_phase[r_fri] <= PH_XFER;
        end else if (i_cmd.commit1 && r_op == OP_SEND && r_frh) begin
            r_phase[r_fri] <= PH_OFFERED;
        end else if (i_cmd.commit3 && r_take && !(w_done < w_size)) begin
            r_phase[r_xi] <= PH_DONE;
        end
    end

    // advance the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (w_push) begin
                r_pend   <= w_new;
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out      <= r_pend;
                    r_out_last <= 1'b0;
                    r_out_v    <= 1'b1;
                end else if (i_ready) begin
                    r_out_v <= 1'b0;
                end
            end else if (i_cmd.flush) begin
                r_out      <= r_pend;
                r_out_last <= 1'b1;
                r_out_v    <= 1'b1;
                r_pend_v   <= 1'b0;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_last  = r_out_last;

endmodule

@@ hw/rtl/chunked_transfer_job_engine_core.sv @@
// Chunked transfer job engine.
// Slave stream: one decoded event per transfer, operation in s_tuser, the
// event fields in s_tdata. Master stream: zero to eight results per event,
// kind in m_tuser, s_tlast-style m_tlast marks the final result of an event.
// APB port: register 0 target_port, register 1 stall_timeout (reset 5).
// Each tick, offer, chunk request, chunk data or user send event walks the job
// table one slot per cycle after its accept cycle; a tick holds at a slot while
// its request cannot be queued. A tick then flushes; an offer, chunk request or
// user send commits its result, if any, and flushes; chunk data commits its
// write, advances its slot and may queue the next request or a completion.
// The next event is accepted only after all results of the current one sit
// in the output register.
// Reset frees every slot; init does the same and keeps the registers. A
// stalled receiver holds the output register and the engine waits at its
// next result; no result is dropped.
// ----------------------------------------------------------------------------
// Chunked transfer job engine top level
// Joins the controller, datapath and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chunked_transfer_job_engine_core_defines.svh"
module chunked_transfer_job_engine_core #(
    parameter int          JOB_SLOTS   = 8,
    parameter logic [31:0] CHUNK_BYTES = 32'd1048576
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // now, job_ident, file length, byte_offset, byte_count, peer_address
    input  logic [223:0]  i_s_tdata,
    // operation
    input  logic [2:0]    i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // slot, ident_out, offset_out, length_out, dest_address, dest_port, pad
    output logic [167:0]  o_m_tdata,
    // kind
    output logic [2:0]    o_m_tuser,
    output logic          o_m_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import ctj_pkg::*;

    localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

    logic [15:0]   r_port;
    logic [7:0]    r_timeout;
    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [IW-1:0] w_idx;
    t_result       w_res;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port    <= 16'd0;
            r_timeout <= 8'd5;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_TARGET_PORT) begin
                r_port <= pwdata[15:0];
            end else begin
                r_timeout <= pwdata[7:0];
            end
        end
    end
    assign prdata = (paddr[2] == REG_STALL_TIMEOUT) ? {24'd0, r_timeout} : {16'd0, r_port};

    ctj_ctrl #(.JOB_SLOTS(JOB_SLOTS), .IW(IW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    ctj_dp #(.JOB_SLOTS(JOB_SLOTS), .IW(IW), .CHUNK_BYTES(CHUNK_BYTES)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_idx     (w_idx),
        .o_sts     (w_sts),
        .i_op      (i_s_tuser),
        .i_in_data (i_s_tdata),
        .i_port    (r_port),
        .i_timeout (r_timeout),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (w_res),
        .o_last    (o_m_tlast)
    );

    assign o_m_tuser = w_res.kind;
    assign o_m_tdata = {5'd0, w_res.port, w_res.dest, w_res.length, w_res.offset,
                        w_res.ident, w_res.slot};

    // an idle engine holds no queued result
    `CTJ_ASSERT(a_idle_empty, i_clk, i_rst_n, o_s_tready |-> !w_sts.pend_v)
    // a non-final result means the event is still in progress
    `CTJ_NEVER(a_partial_busy, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast && o_s_tready)

endmodule
